FILE: hw/rtl/srt_pkg.sv
// shared types, constants and a helper function for the radix-2 srt divider
`default_nettype none

package srt_pkg;

    localparam int unsigned DIVISOR_BITS  = 16;
    localparam int unsigned DIVIDEND_BITS = 2 * DIVISOR_BITS;
    localparam int unsigned PART_W        = DIVISOR_BITS + 2;
    localparam int unsigned SHIFT_W       = $clog2(DIVISOR_BITS);
    localparam int unsigned OPS_W         = 5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_srt_status;

    typedef struct packed {
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [DIVISOR_BITS-1:0]  divisor;
    } t_srt_in;

    typedef struct packed {
        logic [DIVISOR_BITS-1:0] quotient;
        logic [DIVISOR_BITS-1:0] remainder;
        logic [OPS_W-1:0]        op_count;
        t_srt_status             status;
    } t_srt_out;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic reject;
        logic norm;
        logic step;
        logic fix;
    } t_srt_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_zero;
        logic overflow;
    } t_srt_sts;

    // leading-zero count of a nonzero divisor
    function automatic logic [SHIFT_W-1:0] lead_zeros(input logic [DIVISOR_BITS-1:0] d);
        logic [SHIFT_W-1:0] z;
        z = '0;
        for (int i = 0; i < DIVISOR_BITS; i++) begin
            if (d[i]) begin
                z = SHIFT_W'(DIVISOR_BITS - 1 - i);
            end
        end
        return z;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/srt_ctrl.sv
// controller state machine for the radix-2 srt divider
`default_nettype none

module srt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire srt_pkg::t_srt_sts i_sts,
    output srt_pkg::t_srt_cmd      o_cmd,
    output logic                   o_busy,
    output logic                   o_valid
);
    import srt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_NORM,
        S_ITER,
        S_FIX
    } t_state;

    localparam logic [SHIFT_W-1:0] LAST_STEP = SHIFT_W'(DIVISOR_BITS - 1);

    t_state             r_state;
    logic               r_busy;
    logic               r_valid;
    logic [SHIFT_W-1:0] r_cnt;
    logic               bad;

    assign bad = i_sts.div_zero | i_sts.overflow;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.reject = (r_state == S_CHECK) && bad;
        o_cmd.norm   = (r_state == S_NORM);
        o_cmd.step   = (r_state == S_ITER);
        o_cmd.fix    = (r_state == S_FIX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CHECK;
                        r_busy  <= 1'b1;
                    end
                end
                S_CHECK: begin
                    if (bad) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                        r_valid <= 1'b1;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    r_state <= S_ITER;
                    r_cnt   <= '0;
                end
                S_ITER: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/srt_datapath.sv
// datapath of the radix-2 srt divider: partial remainder, quotient digits, result register
`default_nettype none

module srt_datapath (
    input  wire logic              i_clk,
    input  wire srt_pkg::t_srt_in  i_op,
    input  wire srt_pkg::t_srt_cmd i_cmd,
    output srt_pkg::t_srt_sts      o_sts,
    output srt_pkg::t_srt_out      o_result
);
    import srt_pkg::*;

    localparam int unsigned K = DIVISOR_BITS;
    localparam logic signed [PART_W-1:0] HALF = PART_W'(1) << (K - 1);

    logic [DIVIDEND_BITS-1:0] r_num;
    logic [K-1:0]             r_den;
    logic signed [PART_W-1:0] r_part;
    logic [K-1:0]             r_low;
    logic [K-1:0]             r_qpos;
    logic [K-1:0]             r_qneg;
    logic [OPS_W-1:0]         r_ops;
    logic [SHIFT_W-1:0]       r_z;
    t_srt_out                 r_result;

    logic [SHIFT_W-1:0]       z;
    logic [DIVIDEND_BITS-1:0] num_sh;
    logic signed [PART_W-1:0] den_s;
    logic signed [PART_W-1:0] shifted;
    logic signed [PART_W-1:0] fixed_part;
    logic [K-1:0]             quo;

    assign o_sts.div_zero = (r_den == '0);
    assign o_sts.overflow = (r_num[DIVIDEND_BITS-1:K] >= r_den);

    assign z       = lead_zeros(r_den);
    assign num_sh  = r_num << z;
    assign den_s   = $signed({2'b00, r_den});
    assign shifted = $signed({r_part[PART_W-2:0], r_low[K-1]});
    assign fixed_part = (r_part < 0) ? (r_part + den_s) : r_part;
    assign quo     = r_qpos - r_qneg - {{(K-1){1'b0}}, r_part[PART_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= i_op.dividend;
            r_den <= i_op.divisor;
        end
        if (i_cmd.reject) begin
            r_result <= '{quotient: '0, remainder: '0, op_count: '0,
                          status: o_sts.div_zero ? ST_DIV_ZERO : ST_OVERFLOW};
        end
        if (i_cmd.norm) begin
            r_den  <= r_den << z;
            r_z    <= z;
            r_part <= $signed({2'b00, num_sh[DIVIDEND_BITS-1:K]});
            r_low  <= num_sh[K-1:0];
            r_qpos <= '0;
            r_qneg <= '0;
            r_ops  <= '0;
        end
        if (i_cmd.step) begin
            r_low <= r_low << 1;
            // digit +1 at or above one half, -1 below minus one half, else plain shift
            if (shifted >= HALF) begin
                r_part <= shifted - den_s;
                r_qpos <= {r_qpos[K-2:0], 1'b1};
                r_qneg <= {r_qneg[K-2:0], 1'b0};
                r_ops  <= r_ops + 1'b1;
            end else if (shifted < -HALF) begin
                r_part <= shifted + den_s;
                r_qpos <= {r_qpos[K-2:0], 1'b0};
                r_qneg <= {r_qneg[K-2:0], 1'b1};
                r_ops  <= r_ops + 1'b1;
            end else begin
                r_part <= shifted;
                r_qpos <= {r_qpos[K-2:0], 1'b0};
                r_qneg <= {r_qneg[K-2:0], 1'b0};
            end
        end
        if (i_cmd.fix) begin
            // negative remainder gets one more add of the divisor
            r_result <= '{quotient: quo,
                          remainder: fixed_part[K-1:0] >> r_z,
                          op_count: r_ops + {{(OPS_W-1){1'b0}}, r_part[PART_W-1]},
                          status: ST_OK};
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: hw/rtl/srt_radix2_divider_core.sv
// top level of the radix-2 srt divider: controller plus datapath
//
//  channel   ports                 handshake
//  -------   -------------------   -------------------------------------------
//  operands  i_op                  taken at a clock edge with start high, busy low
//  result    o_result              shown for one cycle while o_valid is high
//
//  an item goes through check, normalize, K quotient-digit steps, remainder
//  correction, then the result cycle.
//  zero divisor or quotient overflow returns straight from the check.
//  busy is high for the whole item; a new item may start in the result cycle.
//  reset is synchronous and active low and clears the controller only.
//  the receiver cannot stall: each result is offered once.
`default_nettype none

module srt_radix2_divider_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire srt_pkg::t_srt_in i_op,
    output logic                  busy,
    output logic                  o_valid,
    output srt_pkg::t_srt_out     o_result
);
    import srt_pkg::*;

    t_srt_cmd cmd;
    t_srt_sts sts;

    srt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    srt_datapath u_datapath (
        .i_clk    (i_clk),
        .i_op     (i_op),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/srt_checker.sv
// port-level checks of the radix-2 srt divider, bound to the top level
`default_nettype none

module srt_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_valid,
    input wire srt_pkg::t_srt_out o_result
);
    import srt_pkg::*;

    // a result ends the item, so busy is already low
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted item did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // rejected items carry only the status
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |->
            (o_result.quotient == '0 && o_result.remainder == '0
             && o_result.op_count == '0))
        else $error("rejected item with nonzero fields");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

endmodule

bind srt_radix2_divider_core srt_checker u_srt_checker (.*);

`default_nettype wire
